// ===== design/rsi_pkg.sv =====
package rsi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd3;

endpackage

// ===== design/rsi_mul.sv =====
module rsi_mul #(
    parameter int AW  = 35,
    parameter int BW  = 35,
    parameter int SBW = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    input  logic [SBW-1:0]          in_sb,
    output logic                    out_valid,
    output logic signed [AW+BW-1:0] p,
    output logic [SBW-1:0]          out_sb
);

    localparam int LA = AW / 2;
    localparam int HA = AW - LA;
    localparam int LB = BW / 2;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic [LA-1:0]          a_lo;
    logic [LB-1:0]          b_lo;
    logic signed [HA-1:0]   a_hi;
    logic signed [HB-1:0]   b_hi;

    logic signed [HA+HB-1:0]   hh_reg;
    logic signed [HA+LB:0]     hl_reg;
    logic signed [LA+HB:0]     lh_reg;
    logic [LA+LB-1:0]          ll_reg;
    logic [SBW-1:0]            sb1_reg;
    logic                      v1_reg;
    logic signed [PW-1:0]      p_reg;
    logic signed [PW-1:0]      p_next;
    logic [SBW-1:0]            sb2_reg;
    logic                      v2_reg;

    assign a_lo = a[LA-1:0];
    assign b_lo = b[LB-1:0];
    assign a_hi = a[AW-1:LA];
    assign b_hi = b[BW-1:LB];

    // split into four registered partial products, then sum them into p_reg
    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg  <= a_hi * b_hi;
            hl_reg  <= a_hi * $signed({1'b0, b_lo});
            lh_reg  <= $signed({1'b0, a_lo}) * b_hi;
            ll_reg  <= a_lo * b_lo;
            sb1_reg <= in_sb;
            p_reg   <= p_next;
            sb2_reg <= sb1_reg;
        end
    end

    assign p_next = (PW'(hh_reg) << (LA + LB)) + (PW'(hl_reg) << LA)
                  + (PW'(lh_reg) << LB) + PW'(ll_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign p         = p_reg;
    assign out_sb    = sb2_reg;

endmodule

// ===== design/rsi_sqrt.sv =====
module rsi_sqrt #(
    parameter int MW  = 167,
    parameter int SBW = 1,
    localparam int SQW = (MW + 1) / 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [MW-1:0]   m_in,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [SQW-1:0]  root,
    output logic            inexact,
    output logic [SBW-1:0]  out_sb
);

    localparam int RW = 2 * SQW + 2;

    logic [RW-1:0]  rem_reg  [SQW];
    logic [SQW-1:0] root_reg [SQW];
    logic [SBW-1:0] sb_reg   [SQW];
    logic [SQW-1:0] v_reg;

    // one root bit per stage, most significant first
    for (genvar k = 0; k < SQW; k++) begin : g_stage
        localparam int I = SQW - 1 - k;
        logic [RW-1:0]  rem_in;
        logic [RW-1:0]  trial;
        logic [SQW-1:0] root_in;
        logic [SBW-1:0] sb_in;
        logic           v_in;

        if (k == 0) begin : g_first
            assign rem_in  = RW'(m_in);
            assign root_in = '0;
            assign sb_in   = in_sb;
            assign v_in    = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sb_in   = sb_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        // (2r + 2^i) * 2^i is what setting bit i adds to the square
        assign trial = ((RW'(root_in) << 1) | (RW'(1) << I)) << I;

        always_ff @(posedge aclk) begin
            if (en) begin
                sb_reg[k] <= sb_in;
                if (rem_in >= trial) begin
                    rem_reg[k]  <= rem_in - trial;
                    root_reg[k] <= root_in | (SQW'(1) << I);
                end else begin
                    rem_reg[k]  <= rem_in;
                    root_reg[k] <= root_in;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end
    end

    assign out_valid = v_reg[SQW-1];
    assign root      = root_reg[SQW-1];
    assign inexact   = |rem_reg[SQW-1];
    assign out_sb    = sb_reg[SQW-1];

endmodule

// ===== design/rsi_div.sv =====
module rsi_div #(
    parameter int NW  = 87,
    parameter int DW  = 67,
    parameter int QW  = 33,
    parameter int SBW = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   mag,
    input  logic [DW-1:0]   divisor,
    input  logic            neg,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [QW-1:0]   quo,
    output logic            ovf,
    output logic            out_neg,
    output logic [SBW-1:0]  out_sb
);

    localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [CW-1:0]  rem_reg [QW+1];
    logic [DW-1:0]  d_reg   [QW+1];
    logic [QW-1:0]  quo_reg [QW+1];
    logic [SBW-1:0] sb_reg  [QW+1];
    logic [QW:0]    neg_reg;
    logic [QW:0]    ovf_reg;
    logic [QW:0]    v_reg;

    // entry: flag quotients that do not fit in QW bits
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= CW'(mag);
            d_reg[0]   <= divisor;
            quo_reg[0] <= '0;
            sb_reg[0]  <= in_sb;
            neg_reg[0] <= neg;
            ovf_reg[0] <= CW'(mag) >= (CW'(divisor) << QW);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int I = QW - k;
        logic [CW-1:0] trial;

        assign trial = CW'(d_reg[k-1]) << I;

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k]   <= d_reg[k-1];
                sb_reg[k]  <= sb_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                if (rem_reg[k-1] >= trial) begin
                    rem_reg[k] <= rem_reg[k-1] - trial;
                    quo_reg[k] <= quo_reg[k-1] | (QW'(1) << I);
                end else begin
                    rem_reg[k] <= rem_reg[k-1];
                    quo_reg[k] <= quo_reg[k-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = quo_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign out_neg   = neg_reg[QW];
    assign out_sb    = sb_reg[QW];

endmodule

// ===== design/rsi_outbuf.sv =====
module rsi_outbuf #(
    parameter int DW = 104
) (
    input  logic          aclk,
    input  logic          aresetn,
    output logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_data,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [DW-1:0] m_data
);

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [DW-1:0] out_data_reg, out_data_next;
    logic [DW-1:0] skid_data_reg, skid_data_next;
    logic          push;

    // pipeline moves whenever the skid slot is free
    assign en   = !skid_valid_reg;
    assign push = in_valid && !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = in_data;
            end
        end else if (push) begin
            // output stalled: park the beat
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== design/ray_sphere_intersect.sv =====
// Channel   Ports                                 Direction  Contents
// s_        s_tvalid s_tready s_tdata             in         one ray per beat
// m_        m_tvalid m_tready m_tdata             out        one result per ray
// cfg_      cfg_valid cfg_ready cfg_index cfg_data in        center x/y/z, radius
//
// Fully pipelined: one ray per cycle while s_tready is high, results in input order.
// The pipe holds a bit-per-stage square root followed by two bit-per-stage dividers.
// aresetn (synchronous) empties the pipe and loads center 0 and radius 1.0.
// A stall on m_ parks one beat in a skid slot; s_tready drops only while it is full.
module ray_sphere_intersect
    import rsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int IN_TDW  = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDW = ((3 * COORD_WIDTH + 3 + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [IN_TDW-1:0]      s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hit, t_low, t_high, near_valid, near_t, saturated
    output logic [OUT_TDW-1:0]     m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int SW   = 2 * W + 3;
    localparam int DW   = 2 * SW;
    localparam int MW   = DW + 2 * F + 1;
    localparam int SQW  = (MW + 1) / 2;
    localparam int NW0  = SW + F + 2;
    localparam int QDW  = SW;
    localparam int NNW  = ((NW0 > SQW + 1) ? NW0 : SQW + 1) + 1;
    localparam int MGW  = NNW + 1;
    localparam int QW   = W + 1;
    localparam int SQSB = 1 + QDW + NW0;
    localparam int RES_W = 3 * W + 3;

    localparam logic [W-2:0] RADIUS_ONE = {{(W - 2){1'b0}}, 1'b1} << F;

    logic en;

    // configuration
    logic signed [W-1:0] center_reg [3];
    logic [W-2:0]        radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 3; j++) begin
                center_reg[j] <= '0;
            end
            radius_reg <= RADIUS_ONE;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CENTER_X: center_reg[0] <= cfg_data;
                REG_CENTER_Y: center_reg[1] <= cfg_data;
                REG_CENTER_Z: center_reg[2] <= cfg_data;
                REG_RADIUS:   radius_reg    <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // stage 1: origin relative to center
    logic signed [W:0]   rel_reg [3];
    logic signed [W-1:0] dir_reg [3];
    logic                v1_reg;

    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                rel_reg[j] <= $signed({s_tdata[j*W+W-1], s_tdata[j*W +: W]})
                            - $signed({center_reg[j][W-1], center_reg[j]});
                dir_reg[j] <= s_tdata[(j+3)*W +: W];
            end
        end
    end

    // stage 2: products
    logic signed [2*W-1:0] dd_reg [3];
    logic signed [2*W:0]   rd_reg [3];
    logic signed [2*W+1:0] rr_reg [3];
    logic [2*W-3:0]        r2_reg;
    logic                  v2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                dd_reg[j] <= dir_reg[j] * dir_reg[j];
                rd_reg[j] <= rel_reg[j] * dir_reg[j];
                rr_reg[j] <= rel_reg[j] * rel_reg[j];
            end
            r2_reg <= radius_reg * radius_reg;
        end
    end

    // stage 3: quadratic terms a, b/2, c
    logic signed [SW-1:0] a_reg, bp_reg, c_reg;
    logic                 v3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= SW'(dd_reg[0]) + SW'(dd_reg[1]) + SW'(dd_reg[2]);
            bp_reg <= SW'(rd_reg[0]) + SW'(rd_reg[1]) + SW'(rd_reg[2]);
            c_reg  <= SW'(rr_reg[0]) + SW'(rr_reg[1]) + SW'(rr_reg[2]) - SW'(r2_reg);
        end
    end

    // stages 4-5: b'^2 and a*c
    logic                 bpsq_v, ac_v;
    logic signed [DW-1:0] bpsq_p, ac_p;
    logic [2*SW-1:0]      bpsq_sb;
    logic                 a_zero;

    rsi_mul #(.AW(SW), .BW(SW), .SBW(2 * SW)) u_mul_bpsq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .a         (bp_reg),
        .b         (bp_reg),
        .in_sb     ({a_reg, bp_reg}),
        .out_valid (bpsq_v),
        .p         (bpsq_p),
        .out_sb    (bpsq_sb)
    );

    rsi_mul #(.AW(SW), .BW(SW), .SBW(1)) u_mul_ac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .a         (a_reg),
        .b         (c_reg),
        .in_sb     (a_reg == '0),
        .out_valid (ac_v),
        .p         (ac_p),
        .out_sb    (a_zero)
    );

    // stage 6: discriminant and root numerator terms
    logic signed [SW-1:0]  a_d, bp_d;
    logic signed [DW-1:0]  det;
    logic [MW-1:0]         m_reg;
    logic signed [NW0-1:0] n_reg;
    logic [QDW-1:0]        q_reg;
    logic                  nohit4_reg;
    logic                  v4_reg;

    assign a_d = bpsq_sb[2*SW-1:SW];
    assign bp_d = bpsq_sb[SW-1:0];
    assign det = bpsq_p - ac_p;

    always_ff @(posedge aclk) begin
        if (en) begin
            nohit4_reg <= a_zero || det[DW-1];
            m_reg      <= det[DW-1] ? '0 : {det[DW-2:0], {(2 * F + 2){1'b0}}};
            n_reg      <= NW0'(a_d) - (NW0'(bp_d) <<< (F + 1));
            q_reg      <= {a_d[SW-2:0], 1'b0};
        end
    end

    // square root
    logic            sq_v;
    logic [SQW-1:0]  sq_root;
    logic            sq_inexact;
    logic [SQSB-1:0] sq_sb;

    rsi_sqrt #(.MW(MW), .SBW(SQSB)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .m_in      (m_reg),
        .in_sb     ({nohit4_reg, q_reg, n_reg}),
        .out_valid (sq_v),
        .root      (sq_root),
        .inexact   (sq_inexact),
        .out_sb    (sq_sb)
    );

    // stage: numerators n - ceil(sqrt), n + floor(sqrt)
    logic signed [NW0-1:0] n_s;
    logic signed [NNW-1:0] nl_reg, nh_reg;
    logic [QDW-1:0]        q5_reg;
    logic                  nohit5_reg;
    logic                  v5_reg;

    assign n_s = sq_sb[NW0-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            nl_reg     <= NNW'(n_s) - NNW'(sq_root) - NNW'(sq_inexact);
            nh_reg     <= NNW'(n_s) + NNW'(sq_root);
            q5_reg     <= sq_sb[NW0 +: QDW];
            nohit5_reg <= sq_sb[SQSB-1];
        end
    end

    // stage: magnitudes for floor division
    logic [MGW-1:0] magl_reg, magh_reg;
    logic           negl_reg, negh_reg;
    logic [QDW-1:0] q6_reg;
    logic           nohit6_reg;
    logic           v6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            negl_reg   <= nl_reg[NNW-1];
            negh_reg   <= nh_reg[NNW-1];
            magl_reg   <= nl_reg[NNW-1]
                        ? (MGW'(0) - MGW'(nl_reg)) + MGW'(q5_reg) - MGW'(1)
                        : MGW'(nl_reg);
            magh_reg   <= nh_reg[NNW-1]
                        ? (MGW'(0) - MGW'(nh_reg)) + MGW'(q5_reg) - MGW'(1)
                        : MGW'(nh_reg);
            q6_reg     <= q5_reg;
            nohit6_reg <= nohit5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= bpsq_v && ac_v;
            v5_reg <= sq_v;
            v6_reg <= v5_reg;
        end
    end

    // dividers
    logic          dl_v, dh_v;
    logic [QW-1:0] quo_l, quo_h;
    logic          ovf_l, ovf_h, neg_l, neg_h, nohit_l, nohit_h;

    rsi_div #(.NW(MGW), .DW(QDW), .QW(QW), .SBW(1)) u_div_low (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .mag       (magl_reg),
        .divisor   (q6_reg),
        .neg       (negl_reg),
        .in_sb     (nohit6_reg),
        .out_valid (dl_v),
        .quo       (quo_l),
        .ovf       (ovf_l),
        .out_neg   (neg_l),
        .out_sb    (nohit_l)
    );

    rsi_div #(.NW(MGW), .DW(QDW), .QW(QW), .SBW(1)) u_div_high (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .mag       (magh_reg),
        .divisor   (q6_reg),
        .neg       (negh_reg),
        .in_sb     (nohit6_reg),
        .out_valid (dh_v),
        .quo       (quo_h),
        .ovf       (ovf_h),
        .out_neg   (neg_h),
        .out_sb    (nohit_h)
    );

    // clamp to the coordinate range: returns {saturated, value}
    function automatic logic [W:0] clamp_root(input logic [QW-1:0] uq,
                                              input logic ovf, input logic neg);
        logic          big;
        logic [W-1:0]  v;
        big = 1'b0;
        v   = '0;
        if (neg) begin
            big = ovf || uq[W] || (uq[W-1] && (|uq[W-2:0]));
            v   = big ? {1'b1, {(W - 1){1'b0}}} : W'(0) - uq[W-1:0];
        end else begin
            big = ovf || uq[W] || uq[W-1];
            v   = big ? {1'b0, {(W - 1){1'b1}}} : uq[W-1:0];
        end
        return {big, v};
    endfunction

    logic [W:0]       cl_l, cl_h;
    logic             hit, near_valid, saturated;
    logic [W-1:0]     t_low, t_high, near_t;
    logic [RES_W-1:0] res;

    assign cl_l = clamp_root(quo_l, ovf_l, neg_l);
    assign cl_h = clamp_root(quo_h, ovf_h, neg_h);

    always_comb begin
        hit        = !(nohit_l || nohit_h);
        t_low      = '0;
        t_high     = '0;
        near_valid = 1'b0;
        near_t     = '0;
        saturated  = 1'b0;
        if (hit) begin
            t_low     = cl_l[W-1:0];
            t_high    = cl_h[W-1:0];
            saturated = cl_l[W] || cl_h[W];
            if (!t_low[W-1]) begin
                near_valid = 1'b1;
                near_t     = t_low;
            end else if (!t_high[W-1]) begin
                near_valid = 1'b1;
                near_t     = t_high;
            end
        end
    end

    assign res = {saturated, near_t, near_valid, t_high, t_low, hit};

    rsi_outbuf #(.DW(OUT_TDW)) u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dl_v && dh_v),
        .in_data  (OUT_TDW'(res)),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata)
    );

endmodule

// ===== design/rsi_checker.sv =====
module rsi_checker #(
    parameter int COORD_WIDTH = 32,
    localparam int OUT_TDW = ((3 * COORD_WIDTH + 3 + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [OUT_TDW-1:0] m_tdata
);

    localparam int W = COORD_WIDTH;

    logic                hit, near_valid, saturated;
    logic signed [W-1:0] t_low, t_high, near_t;

    assign hit        = m_tdata[0];
    assign t_low      = m_tdata[W:1];
    assign t_high     = m_tdata[2*W:W+1];
    assign near_valid = m_tdata[2*W+1];
    assign near_t     = m_tdata[3*W+1:2*W+2];
    assign saturated  = m_tdata[3*W+2];

    a_out_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_miss_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !hit |-> t_low == 0 && t_high == 0 && !near_valid
                             && near_t == 0 && !saturated)
        else $error("miss result carries nonzero fields");

    a_root_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && hit |-> t_low <= t_high)
        else $error("roots out of order");

    a_near_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && near_valid |-> near_t >= 0
                                   && (near_t == t_low || near_t == t_high))
        else $error("near root is not a non-negative root");

endmodule

bind ray_sphere_intersect rsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/ray_sphere_intersect_test.sv =====
`timescale 1ns / 1ps

module ray_sphere_intersect_test;
    import rsi_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int XW = 320;
    localparam int IN_W = 192;
    localparam int OUT_W = 104;
    localparam int PIPE_LAT = 3 * CW + FB + 15;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic signed [CW-1:0] org[3];
        logic signed [CW-1:0] dir[3];
    } ray_t;

    // highest field first, so hit lands in bit 0 as on m_tdata
    typedef struct packed {
        logic              saturated;
        logic signed [CW-1:0] near_t;
        logic              near_valid;
        logic signed [CW-1:0] t_high;
        logic signed [CW-1:0] t_low;
        logic              hit;
    } hit_t;

    typedef struct {
        ray_t ray;
        bit   typed;
        hit_t want;
    } row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0]    cfg_data;

    logic signed [CW-1:0] sph_center[3];
    logic [CW-2:0]        sph_radius;

    hit_t hit_expect_q[$];
    int   mismatches;
    bit   rx_steady;
    bit   rx_hold_req;
    int   rx_hold_cnt;
    int   rx_idle_pct;
    int   tx_idle_pct;
    int   quiet_cycles;

    ray_sphere_intersect u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // floor division for a positive divisor
    function automatic logic signed [XW-1:0] floor_div(logic signed [XW-1:0] num,
                                                        logic signed [XW-1:0] den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic logic signed [XW-1:0] clamp_t(logic signed [XW-1:0] v, ref bit sat);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = (XW'(1) <<< (CW - 1)) - 1;
        lo = -(XW'(1) <<< (CW - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic hit_t sphere_hit_model(ray_t r);
        logic signed [XW-1:0] dv, rel, a, bp, c, det, n, m, q, s, sc, trial, tl, th, rad;
        hit_t res;
        bit   sat;
        res = '0;
        sat = 1'b0;
        a = 0;
        bp = 0;
        c = 0;
        for (int i = 0; i < 3; i++) begin
            dv = r.dir[i];
            rel = r.org[i];
            rel = rel - sph_center[i];
            a = a + dv * dv;
            bp = bp + rel * dv;
            c = c + rel * rel;
        end
        rad = {1'b0, sph_radius};
        c = c - rad * rad;
        det = bp * bp - a * c;
        if (a == 0 || det < 0)
            return res;
        n = a - (bp <<< (FB + 1));
        m = det <<< (2 * FB + 2);
        q = a + a;
        s = 0;
        for (int i = 100; i >= 0; i--) begin
            trial = s | (XW'(1) <<< i);
            if (trial * trial <= m)
                s = trial;
        end
        sc = (s * s < m) ? s + 1 : s;
        tl = clamp_t(floor_div(n - sc, q), sat);
        th = clamp_t(floor_div(n + s, q), sat);
        res.hit = 1'b1;
        res.t_low = tl[CW-1:0];
        res.t_high = th[CW-1:0];
        if (tl >= 0) begin
            res.near_valid = 1'b1;
            res.near_t = tl[CW-1:0];
        end else if (th >= 0) begin
            res.near_valid = 1'b1;
            res.near_t = th[CW-1:0];
        end
        res.saturated = sat;
        return res;
    endfunction

    task automatic send_ray(ray_t r, bit typed, hit_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
        do @(posedge aclk); while (!s_tready);
        hit_expect_q.push_back(typed ? want : sphere_hit_model(r));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (hit_expect_q.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LAT + 10) @(posedge aclk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last beat
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CENTER_X: sph_center[0] = val;
            REG_CENTER_Y: sph_center[1] = val;
            REG_CENTER_Z: sph_center[2] = val;
            REG_RADIUS:   sph_radius = val[CW-2:0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                              logic [CW-1:0] rad);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rad);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] near_offset(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    // mostly rays launched near the sphere, some fully random
    function automatic ray_t random_ray();
        ray_t r;
        int   kind;
        int   span;
        kind = $urandom_range(9);
        span = 1 << $urandom_range(12, 22);
        for (int i = 0; i < 3; i++) begin
            if (kind < 2) begin
                r.org[i] = $urandom;
                r.dir[i] = $urandom;
            end else begin
                r.org[i] = sph_center[i] + near_offset(span);
                r.dir[i] = (kind == 2) ? 32'($urandom) : near_offset(1 << $urandom_range(4, 20));
            end
        end
        if (kind == 3)
            r.dir[$urandom_range(2)] = 0;
        return r;
    endfunction

    function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_t r;
        r.org[0] = ox;
        r.org[1] = oy;
        r.org[2] = oz;
        r.dir[0] = dx;
        r.dir[1] = dy;
        r.dir[2] = dz;
        return r;
    endfunction

    // receiver: random stalls, optional long hold-off
    always @(posedge aclk) begin
        if (rx_hold_req && rx_hold_cnt == 0)
            rx_hold_cnt <= 600;
        else if (rx_hold_cnt > 0)
            rx_hold_cnt <= rx_hold_cnt - 1;
        if (rx_hold_cnt > 1 || (rx_hold_req && rx_hold_cnt == 0))
            m_tready <= 1'b0;
        else
            m_tready <= rx_steady || ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        hit_t got;
        hit_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[3*CW+2:0];
            if (hit_expect_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                mismatches++;
            end else begin
                exp_r = hit_expect_q.pop_front();
                if (got.hit !== exp_r.hit || got.t_low !== exp_r.t_low
                        || got.t_high !== exp_r.t_high || got.near_valid !== exp_r.near_valid
                        || got.near_t !== exp_r.near_t || got.saturated !== exp_r.saturated) begin
                    $display("%0t: expected hit=%b t_low=%h t_high=%h near=%b/%h sat=%b",
                             $time, exp_r.hit, exp_r.t_low, exp_r.t_high,
                             exp_r.near_valid, exp_r.near_t, exp_r.saturated);
                    $display("%0t:   actual hit=%b t_low=%h t_high=%h near=%b/%h sat=%b",
                             $time, got.hit, got.t_low, got.t_high,
                             got.near_valid, got.near_t, got.saturated);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        hit_t z;
        hit_t unit;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        mismatches = 0;
        rx_steady = 1'b0;
        rx_hold_req = 1'b0;
        rx_hold_cnt = 0;
        rx_idle_pct = 37;
        tx_idle_pct = 37;
        quiet_cycles = 0;
        sph_center[0] = 0;
        sph_center[1] = 0;
        sph_center[2] = 0;
        sph_radius = 31'd65536;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        z = '0;
        unit = '0;
        unit.hit = 1'b1;
        unit.t_low = -32'sd65536;
        unit.t_high = 32'sd65536;
        unit.near_valid = 1'b1;
        unit.near_t = 32'sd65536;

        // directed rows against the reset sphere: unit radius at the origin
        rows.push_back('{mk_ray(0, 0, 0, 0, 0, 0), 1'b1, z});
        rows.push_back('{mk_ray(32'h7fffffff, 5, -9, 0, 0, 0), 1'b1, z});
        rows.push_back('{mk_ray(0, 0, 0, 65536, 0, 0), 1'b1, unit});
        rows.push_back('{mk_ray(0, 0, 0, 0, 65536, 0), 1'b1, unit});
        rows.push_back('{mk_ray(0, 0, 0, 0, 0, -65536), 1'b1, unit});
        rows.push_back('{mk_ray(0, 5 << 16, 0, 65536, 0, 0), 1'b1, z});
        rows.push_back('{mk_ray(-(3 << 16), 65536, 0, 65536, 0, 0), 1'b0, z});
        rows.push_back('{mk_ray(-(3 << 16), 0, 0, 65536, 0, 0), 1'b0, z});
        rows.push_back('{mk_ray(3 << 16, 0, 0, 65536, 0, 0), 1'b0, z});
        rows.push_back('{mk_ray(3 << 16, 0, 0, 65536, 0, 0), 1'b0, z});
        rows.push_back('{mk_ray(-(3 << 16), 0, 0, 1, 0, 0), 1'b0, z});
        rows.push_back('{mk_ray(0, 0, 0, 1, 1, 1), 1'b0, z});
        rows.push_back('{mk_ray(32'h80000000, 32'h80000000, 32'h80000000,
                                32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b0, z});
        rows.push_back('{mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                32'h80000000, 32'h80000000, 32'h80000000), 1'b0, z});
        rows.push_back('{mk_ray(-1, -1, -1, -1, -1, -1), 1'b0, z});
        rows.push_back('{mk_ray(32'h80000000, 0, 0, 32'h80000000, 0, 0), 1'b0, z});
        rows.push_back('{mk_ray(-(1 << 16), 0, 0, 65536, 0, 0), 1'b0, z});
        rows.push_back('{mk_ray(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f,
                                32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0), 1'b0, z});
        foreach (rows[i])
            send_ray(rows[i].ray, rows[i].typed, rows[i].want);
        drain_results();

        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_sphere(0, 0, 0, 32'h0);
                1: set_sphere(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff);
                2: set_sphere(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
                default: set_sphere(near_offset(1 << 24), near_offset(1 << 24),
                                    near_offset(1 << 24),
                                    {1'($urandom_range(1)),
                                     31'($urandom_range(1, 1 << 22))});
            endcase
            rx_steady = (phase == 4);
            tx_idle_pct = (phase == 4) ? 0 : 37;
            for (int k = 0; k < 250; k++) begin
                if (phase == 3 && k == 40)
                    rx_hold_req = 1'b1;
                if (phase == 3 && k == 60)
                    rx_hold_req = 1'b0;
                send_ray(random_ray(), 1'b0, z);
            end
            drain_results();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
